>>> rtl/core/twt_pkg.sv
// Shared types and constants for the tag whitelist table.
package twt_pkg;

	localparam int unsigned TAG_SLOTS_DEF = 32;
	localparam int unsigned TAG_W         = 64;
	localparam int unsigned CMD_W         = 2;
	localparam int unsigned STATUS_W      = 2;
	localparam int unsigned ENTRY_W       = 6;
	localparam int unsigned RES_W         = STATUS_W + 1 + ENTRY_W;
	localparam int unsigned OUT_TDATA_W   = ((RES_W + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_DUP      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_EXEC,
		SEQ_MOVE,
		SEQ_DONE
	} seq_state_t;

endpackage

>>> rtl/core/twt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twt_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/tag_whitelist_table_unit.sv
// Top level of the tag whitelist table: command sequencer, shared tag compare and result register.
//
// Commands arrive on the s_axis channel: tuser carries the command (add, remove,
// lookup, clear) and tdata the 64-bit tag. Each command gives exactly one result
// transfer on m_axis with status, match flag and the entry count after the command.
// The tags sit in a RAM with registered read; a single 64-bit comparator walks the
// stored entries one per cycle. A command passes through an accept step, a scan of
// the stored entries, an execute step, a move step when a remove moves the last
// entry into the hole, and a step that loads the result. A clear skips the scan and
// the execute step. The scan length, set by the one RAM read port, fixes the rate.
// s_axis_tready is high only while the sequencer is idle.
// When the receiver stalls, the result holds in the output register; the next
// command may be accepted and scanned meanwhile, and its result waits until the
// output register is free.
// Reset clears the entry count and the sequencer; the RAM contents are not cleared,
// since entries at or above the count are never used.
module tag_whitelist_table_unit #(
	parameter int unsigned TAG_SLOTS = twt_pkg::TAG_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [twt_pkg::TAG_W-1:0]        s_axis_tdata,  // [63:0] tag_id
	input  logic [twt_pkg::CMD_W-1:0]        s_axis_tuser,  // [1:0] cmd
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [twt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // [1:0] status, [2] match,
	                                                        // [8:3] entry_count, zero above
);

	import twt_pkg::*;

	localparam int unsigned IDX_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(TAG_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TAG_SLOTS);

	seq_state_t state_q, state_d;

	cmd_t                cmd_q;
	logic [TAG_W-1:0]    tag_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                cmp_vld_s1;
	logic [IDX_W-1:0]    cmp_idx_s1;
	logic                found_q;
	logic [IDX_W-1:0]    slot_q;
	status_t             res_status_q;
	logic                res_match_q;
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [TAG_W-1:0]    ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [TAG_W-1:0]    ram_rdata;

	logic                in_xfer;
	logic                scan_issue;
	logic                scan_done;
	logic                tag_hit;
	logic [CNT_W-1:0]    last_cnt;
	logic                add_ok;
	logic                move_needed;
	logic                out_free;

	twt_ram #(
		.WIDTH (TAG_W),
		.DEPTH (TAG_SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_xfer     = s_axis_tvalid && s_axis_tready;
	assign scan_issue  = scan_idx_q < count_q;
	assign scan_done   = !scan_issue && !cmp_vld_s1;
	assign tag_hit     = cmp_vld_s1 && (ram_rdata == tag_q);
	assign last_cnt    = count_q - CNT_W'(1);
	assign add_ok      = (cmd_q == CMD_ADD) && !found_q && (count_q < SLOTS_C);
	assign move_needed = CNT_W'(slot_q) < last_cnt;
	assign out_free    = !m_tvalid_q || m_axis_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (cmd_t'(s_axis_tuser) == CMD_CLEAR) ? SEQ_DONE : SEQ_SCAN;
				end
			end
			SEQ_SCAN: begin
				if (scan_done) begin
					state_d = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				if ((cmd_q == CMD_REMOVE) && found_q && move_needed) begin
					state_d = SEQ_MOVE;
				end else begin
					state_d = SEQ_DONE;
				end
			end
			SEQ_MOVE: begin
				state_d = SEQ_DONE;
			end
			SEQ_DONE: begin
				if (out_free) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs: input handshake and RAM port control.
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = count_q[IDX_W-1:0];
		ram_wdata     = tag_q;
		ram_raddr     = scan_idx_q[IDX_W-1:0];
		unique case (state_q)
			SEQ_IDLE: begin
				s_axis_tready = 1'b1;
			end
			SEQ_EXEC: begin
				// A successful add writes the new tag; a remove fetches the last entry.
				ram_we    = add_ok;
				ram_raddr = last_cnt[IDX_W-1:0];
			end
			SEQ_MOVE: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = ram_rdata;
			end
			SEQ_SCAN, SEQ_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == SEQ_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				SEQ_IDLE: begin
					scan_idx_q <= '0;
					cmp_vld_s1 <= 1'b0;
					found_q    <= 1'b0;
					if (in_xfer && (cmd_t'(s_axis_tuser) == CMD_CLEAR)) begin
						count_q <= '0;
					end
				end
				SEQ_SCAN: begin
					cmp_vld_s1 <= scan_issue;
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (tag_hit) begin
						found_q <= 1'b1;
					end
				end
				SEQ_EXEC: begin
					if (add_ok) begin
						count_q <= count_q + CNT_W'(1);
					end else if ((cmd_q == CMD_REMOVE) && found_q) begin
						count_q <= last_cnt;
					end
				end
				SEQ_MOVE, SEQ_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q        <= cmd_t'(s_axis_tuser);
			tag_q        <= s_axis_tdata;
			res_status_q <= ST_DONE;
			res_match_q  <= 1'b0;
		end
		if (state_q == SEQ_SCAN) begin
			cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
			if (tag_hit && !found_q) begin
				slot_q <= cmp_idx_s1;
			end
		end
		if (state_q == SEQ_EXEC) begin
			res_match_q <= found_q;
			priority if (cmd_q == CMD_ADD) begin
				if (found_q) begin
					res_status_q <= ST_DUP;
				end else if (!add_ok) begin
					res_status_q <= ST_FULL;
				end else begin
					res_status_q <= ST_DONE;
				end
			end else begin
				res_status_q <= found_q ? ST_DONE : ST_NOTFOUND;
			end
		end
		if ((state_q == SEQ_DONE) && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({ENTRY_W'(count_q), res_match_q, res_status_q});
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SLOTS_C)
		else $error("entry count above table size");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_SCAN) |-> !ram_we)
		else $error("table written during scan");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) < SLOTS_C))
		else $error("table write beyond last slot");

	a_remove_decrements: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_EXEC && cmd_q == CMD_REMOVE && found_q)
		|=> (count_q == $past(last_cnt)))
		else $error("successful remove did not decrement the count");

	a_move_reads_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_MOVE) |-> (CNT_W'(slot_q) < count_q))
		else $error("move targets a slot outside the list");

endmodule
